[rtl/hpc_pkg.sv]
package hpc_pkg;

  localparam int FRAC_BITS = 8;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int DV_W  = 29;
  localparam int AX_W  = 28;
  localparam int PRD_W = 2 * AX_W;
  localparam int SUM_W = PRD_W + 1;
  localparam int SQ_W  = SUM_W + 1;
  localparam int CAP_W = 20;
  localparam int MAG_W = 29;
  localparam int QB    = CAP_W;
  localparam int MS_W  = 9;

  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_HOLD    = 3'd1;
  localparam logic [2:0] MODE_STATION = 3'd2;
  localparam logic [2:0] MODE_CRUISE  = 3'd3;
  localparam logic [2:0] MODE_RETURN  = 3'd4;

  localparam logic [3:0] G_FIRED     = 4'd0;
  localparam logic [3:0] G_OFF       = 4'd1;
  localparam logic [3:0] G_NOSTATE   = 4'd2;
  localparam logic [3:0] G_BAILED    = 4'd3;
  localparam logic [3:0] G_STALE     = 4'd4;
  localparam logic [3:0] G_BAILOUT   = 4'd5;
  localparam logic [3:0] G_INVULN    = 4'd6;
  localparam logic [3:0] G_CONGESTED = 4'd7;
  localparam logic [3:0] G_SKILL     = 4'd8;
  localparam logic [3:0] G_CADENCE   = 4'd9;
  localparam logic [3:0] G_DEADBAND  = 4'd10;
  localparam logic [3:0] G_FAIL      = 4'd11;

  localparam logic [2:0] REG_BOUNDS_VALID = 3'd0;
  localparam logic [2:0] REG_BOUND_LEFT   = 3'd1;
  localparam logic [2:0] REG_BOUND_RIGHT  = 3'd2;
  localparam logic [2:0] REG_BOUND_TOP    = 3'd3;
  localparam logic [2:0] REG_BOUND_BOTTOM = 3'd4;
  localparam logic [2:0] REG_SPEED_SCALE  = 3'd5;
  localparam logic [2:0] REG_SLACK_X      = 3'd6;
  localparam logic [2:0] REG_SLACK_Y      = 3'd7;

  localparam logic UOP_SQRT = 1'b0;
  localparam logic UOP_DIV  = 1'b1;

  localparam logic [31:0] ISSUE_MS       = 32'd90;
  localparam logic [31:0] ISSUE_EMERG_MS = 32'd20;
  localparam logic [31:0] MS_LO          = 32'd30;
  localparam logic [31:0] MS_HI          = 32'd400;

  localparam int DEADBAND  = 12 * ONE;
  localparam int P_GAIN    = 7;
  localparam int FALL_VY   = -850 * ONE;
  localparam int RESCUE_V  = 300 * ONE;
  localparam int BAIL_DROP = 420 * ONE;
  localparam int BRAKE_K   = 5;
  localparam int CMD_LIM   = 1700 * ONE;
  localparam int QUIET_V   = 8 * ONE;
  localparam int FF_BASE   = 30 * ONE;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [2:0]         mode;
    logic signed [23:0] setpoint_x;
    logic signed [23:0] setpoint_y;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [5:0]         status_flags;
  } hpc_in_t;

  typedef struct packed {
    logic               fired;
    logic [3:0]         guard_code;
    logic               emergency;
    logic signed [19:0] cmd_vx;
    logic signed [19:0] cmd_vy;
    logic signed [19:0] desired_vx;
    logic signed [19:0] desired_vy;
    logic [17:0]        trim_vy;
    logic [31:0]        since_ms;
  } hpc_out_t;

  typedef struct packed {
    logic start;
    logic op;
  } hpc_unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hpc_unit_rsp_t;

endpackage

[rtl/hpc_if.sv]
interface hpc_in_if;
  logic             valid;
  logic             ready;
  hpc_pkg::hpc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hpc_out_if;
  logic              valid;
  logic              ready;
  hpc_pkg::hpc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/hpc_root_div.sv]
module hpc_root_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hpc_pkg::hpc_unit_req_t       req,
  input  logic [hpc_pkg::SQ_W-1:0]     opa,
  input  logic [hpc_pkg::MAG_W-1:0]    opb,
  output hpc_pkg::hpc_unit_rsp_t       rsp,
  output logic [hpc_pkg::MAG_W-1:0]    result
);
  import hpc_pkg::*;

  localparam int SQ_STEPS = SQ_W / 2;
  localparam int CNT_W    = $clog2(SQ_STEPS);

  logic             busy_r;
  logic             done_r;
  logic             op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SQ_W-1:0]  v_r;
  logic [SQ_W-1:0]  r_r;
  logic [SQ_W-1:0]  bit_r;
  logic [MAG_W-1:0] rem_r;
  logic [MAG_W-1:0] div_r;
  logic [QB-1:0]    num_r;
  logic [QB-1:0]    q_r;

  logic [SQ_W-1:0]  t_sq;
  logic [MAG_W:0]   trial;
  logic             ge_div;

  assign t_sq   = r_r + bit_r;
  assign trial  = {rem_r, num_r[QB-1]};
  assign ge_div = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          op_r   <= req.op;
          if (req.op == UOP_DIV) begin
            cnt_r <= CNT_W'(QB - 1);
            rem_r <= opa[QB+MAG_W-1:QB];
            num_r <= opa[QB-1:0];
            div_r <= opb;
            q_r   <= '0;
          end else begin
            cnt_r <= CNT_W'(SQ_STEPS - 1);
            v_r   <= opa;
            r_r   <= '0;
            bit_r <= SQ_W'(1) << (SQ_W - 2);
          end
        end
      end else begin
        if (op_r == UOP_DIV) begin
          rem_r <= ge_div ? MAG_W'(trial - {1'b0, div_r}) : trial[MAG_W-1:0];
          num_r <= num_r << 1;
          q_r   <= {q_r[QB-2:0], ge_div};
        end else begin
          if (v_r >= t_sq) begin
            v_r <= v_r - t_sq;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = (op_r == UOP_DIV) ? MAG_W'(q_r) : r_r[MAG_W-1:0];

endmodule

[rtl/hover_position_controller.sv]
// Channel      Direction  Handshake    Payload
// in_ch        input      valid/ready  one control tick (hpc_in_t)
// out_ch       output     valid/ready  one guard result and command (hpc_out_t)
// psel..prdata in/out     APB r/w      eight configuration registers
//
// A tick stopped by an early guard goes straight to the output stage; others
// run the law, envelope and, unless they bail out, multiply stages, and a speed
// vector over the cap adds the 29-step square root and two 20-step divisions in
// the shared iterative unit. A new transaction is accepted only when idle. Reset
// is synchronous, active low and clears configuration and control state only.
// A stalled result holds in the output register; the next transaction may be
// accepted while it waits, and its own result waits for the register.
module hover_position_controller #(
  parameter int STALE_LIMIT = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  hpc_in_if.sink            in_ch,
  hpc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hpc_pkg::*;

  localparam int CNT_W = $clog2(STALE_LIMIT + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GUARD = 4'd1;
  localparam logic [3:0] S_LAW   = 4'd2;
  localparam logic [3:0] S_ENV   = 4'd3;
  localparam logic [3:0] S_MXX   = 4'd4;
  localparam logic [3:0] S_MYY   = 4'd5;
  localparam logic [3:0] S_MCC   = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_MX    = 4'd9;
  localparam logic [3:0] S_DX    = 4'd10;
  localparam logic [3:0] S_MY    = 4'd11;
  localparam logic [3:0] S_DY    = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  // Configuration registers.
  logic               bounds_valid_r;
  logic signed [15:0] bound_left_r;
  logic signed [15:0] bound_right_r;
  logic signed [15:0] bound_top_r;
  logic signed [15:0] bound_bottom_r;
  logic [9:0]         speed_scale_r;
  logic [9:0]         slack_x_r;
  logic [9:0]         slack_y_r;

  logic               cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_valid_r <= 1'b0;
      bound_left_r   <= '0;
      bound_right_r  <= '0;
      bound_top_r    <= '0;
      bound_bottom_r <= '0;
      speed_scale_r  <= 10'd256;
      slack_x_r      <= '0;
      slack_y_r      <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_BOUNDS_VALID: bounds_valid_r <= pwdata[0];
        REG_BOUND_LEFT:   bound_left_r   <= pwdata[15:0];
        REG_BOUND_RIGHT:  bound_right_r  <= pwdata[15:0];
        REG_BOUND_TOP:    bound_top_r    <= pwdata[15:0];
        REG_BOUND_BOTTOM: bound_bottom_r <= pwdata[15:0];
        REG_SPEED_SCALE:  speed_scale_r  <= pwdata[9:0];
        REG_SLACK_X:      slack_x_r      <= pwdata[9:0];
        REG_SLACK_Y:      slack_y_r      <= pwdata[9:0];
        default:          bounds_valid_r <= bounds_valid_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BOUNDS_VALID: prdata = {31'd0, bounds_valid_r};
      REG_BOUND_LEFT:   prdata = {16'd0, bound_left_r};
      REG_BOUND_RIGHT:  prdata = {16'd0, bound_right_r};
      REG_BOUND_TOP:    prdata = {16'd0, bound_top_r};
      REG_BOUND_BOTTOM: prdata = {16'd0, bound_bottom_r};
      REG_SPEED_SCALE:  prdata = {22'd0, speed_scale_r};
      REG_SLACK_X:      prdata = {22'd0, slack_x_r};
      REG_SLACK_Y:      prdata = {22'd0, slack_y_r};
      default:          prdata = '0;
    endcase
  end

  // Sequencer state and per-tick registers.
  logic [3:0]              state_r;
  hpc_in_t                 in_r;
  logic [31:0]             last_r;
  logic                    bailed_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [23:0]             snap_r [4];
  logic [CAP_W-1:0]        cap_r;
  logic [31:0]             since_r;
  logic [MS_W-1:0]         ms_r;
  logic signed [DV_W-1:0]  dvx_r;
  logic signed [DV_W-1:0]  dvy_r;
  logic                    emerg_r;
  logic                    early_r;
  logic [3:0]              code_r;
  logic [PRD_W-1:0]        mul_r;
  logic [SUM_W-1:0]        sum_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    out_valid_r;
  hpc_out_t                out_r;

  logic                    in_acc;
  logic                    out_free;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Guard stage.
  logic             have;
  logic             onfh;
  logic             bail_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_nxt;
  logic             match;
  logic [9:0]       k_c;
  logic [9:0]       base_c;
  logic [31:0]      cap_c;
  logic [31:0]      since_c;
  logic [MS_W-1:0]  ms_c;

  assign have     = in_r.status_flags[0];
  assign onfh     = in_r.status_flags[1];
  assign bail_eff = (have && onfh) ? 1'b0 : bailed_r;
  assign cnt_eff  = (have && onfh) ? '0 : cnt_r;
  assign match    = (in_r.pos_x == snap_r[0]) && (in_r.pos_y == snap_r[1]) &&
                    (in_r.vel_x == snap_r[2]) && (in_r.vel_y == snap_r[3]);

  always_comb begin
    if (!match) cnt_nxt = '0;
    else if (cnt_eff < CNT_W'(STALE_LIMIT)) cnt_nxt = cnt_eff + 1'b1;
    else cnt_nxt = cnt_eff;

    if (speed_scale_r < 10'd64) k_c = 10'd64;
    else if (speed_scale_r > 10'd768) k_c = 10'd768;
    else k_c = speed_scale_r;

    case (in_r.mode)
      MODE_CRUISE:  base_c = 10'd620;
      MODE_RETURN: begin
        base_c = 10'd660;
        if (k_c < 10'd256) k_c = 10'd256;
      end
      MODE_STATION: base_c = 10'd480;
      MODE_HOLD:    base_c = 10'd360;
      default:      base_c = 10'd0;
    endcase
    cap_c = ((32'(base_c) * 32'(k_c)) << FRAC_BITS) >> 8;

    since_c = (last_r != '0) ? (in_r.now_ms - last_r) : ISSUE_MS;
    if (since_c < MS_LO) ms_c = MS_W'(MS_LO);
    else if (since_c > MS_HI) ms_c = MS_W'(MS_HI);
    else ms_c = since_c[MS_W-1:0];
  end

  // Proportional law and fall rescue.
  logic signed [31:0] ex;
  logic signed [31:0] ey;
  logic signed [31:0] vy32;
  logic signed [DV_W-1:0] dvx_law;
  logic signed [DV_W-1:0] dvy_law;
  logic                   em_law;

  assign ex   = 32'(in_r.setpoint_x) - 32'(in_r.pos_x);
  assign ey   = 32'(in_r.setpoint_y) - 32'(in_r.pos_y);
  assign vy32 = 32'(in_r.vel_y);

  always_comb begin
    dvx_law = '0;
    dvy_law = '0;
    em_law  = 1'b0;
    if (ex > DEADBAND || ex < -DEADBAND) dvx_law = DV_W'(ex * P_GAIN);
    if (!onfh && (ey > DEADBAND || ey < -DEADBAND)) dvy_law = DV_W'(ey * P_GAIN);
    if (!onfh && vy32 < FALL_VY) begin
      dvy_law = DV_W'(RESCUE_V);
      em_law  = 1'b1;
    end
  end

  // Bounds envelope and wall braking.
  logic signed [31:0] rawl, rawr, lb, rb, tb, bb, x32, y32, dvx_e, dvy_e, room;
  logic               em_e;
  logic               bail_e;

  always_comb begin
    rawl   = 32'(bound_left_r) * ONE;
    rawr   = 32'(bound_right_r) * ONE;
    lb     = rawl - $signed(32'(slack_x_r)) * ONE;
    rb     = rawr + $signed(32'(slack_x_r)) * ONE;
    tb     = 32'(bound_top_r) * ONE - $signed(32'(slack_y_r)) * ONE;
    bb     = 32'(bound_bottom_r) * ONE + $signed(32'(slack_y_r)) * ONE;
    x32    = 32'(in_r.pos_x);
    y32    = 32'(in_r.pos_y);
    dvx_e  = 32'(dvx_r);
    dvy_e  = 32'(dvy_r);
    em_e   = emerg_r;
    bail_e = 1'b0;
    room   = '0;
    if (bounds_valid_r && rb > lb && bb > tb) begin
      if (x32 < lb) begin
        dvx_e = RESCUE_V;
        em_e  = 1'b1;
      end else if (x32 > rb) begin
        dvx_e = -RESCUE_V;
        em_e  = 1'b1;
      end
      if (y32 < tb) begin
        dvy_e = RESCUE_V;
        em_e  = 1'b1;
        if (y32 < tb - BAIL_DROP) bail_e = 1'b1;
      end else if (y32 > bb) begin
        dvy_e = -$signed(32'(cap_r));
        em_e  = 1'b1;
      end
      room = (rawr - x32) * BRAKE_K;
      if (dvx_e > room) dvx_e = room;
      room = (rawl - x32) * BRAKE_K;
      if (dvx_e < room) dvx_e = room;
      room = (bb - y32) * BRAKE_K;
      if (dvy_e > room) dvy_e = room;
      room = (tb - y32) * BRAKE_K;
      if (dvy_e < room) dvy_e = room;
    end
  end

  // Shared multiplier and iterative unit.
  logic [AX_W-1:0]  ax;
  logic [AX_W-1:0]  ay;
  logic [AX_W-1:0]  mul_a;
  logic [AX_W-1:0]  mul_b;
  hpc_unit_req_t    u_req;
  hpc_unit_rsp_t    u_rsp;
  logic [SQ_W-1:0]  u_opa;
  logic [MAG_W-1:0] u_res;
  logic signed [DV_W-1:0] q_signed;
  logic             neg_sel;

  assign ax = AX_W'(dvx_r < 0 ? -dvx_r : dvx_r);
  assign ay = AX_W'(dvy_r < 0 ? -dvy_r : dvy_r);

  always_comb begin
    mul_a = ax;
    mul_b = ax;
    case (state_r)
      S_MYY: begin
        mul_a = ay;
        mul_b = ay;
      end
      S_MCC: begin
        mul_a = AX_W'(cap_r);
        mul_b = AX_W'(cap_r);
      end
      S_MX: mul_b = AX_W'(cap_r);
      S_MY: begin
        mul_a = ay;
        mul_b = AX_W'(cap_r);
      end
      default: mul_a = ax;
    endcase
  end

  assign u_req.start = (state_r == S_CMP && sum_r > SUM_W'(mul_r)) ||
                       ((state_r == S_DX || state_r == S_DY) &&
                        !u_rsp.busy && !u_rsp.done);
  assign u_req.op    = (state_r == S_CMP) ? UOP_SQRT : UOP_DIV;
  assign u_opa       = (state_r == S_CMP) ? SQ_W'(sum_r) : SQ_W'(mul_r);
  assign neg_sel     = (state_r == S_DX) ? (dvx_r < 0) : (dvy_r < 0);
  assign q_signed    = neg_sel ? -$signed(DV_W'(u_res)) : $signed(DV_W'(u_res));

  hpc_root_div u_root_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (u_req),
    .opa    (u_opa),
    .opb    (mag_r),
    .rsp    (u_rsp),
    .result (u_res)
  );

  // Command forming and late guards.
  logic signed [31:0] dvx32, dvx_abs, vx32, vx_abs, ff, cvx, cvy;
  logic               same;
  logic [31:0]        dt;
  logic [3:0]         code_c;
  hpc_out_t           res_c;

  always_comb begin
    dvx32   = 32'(dvx_r);
    vx32    = 32'(in_r.vel_x);
    dvx_abs = dvx32 < 0 ? -dvx32 : dvx32;
    vx_abs  = vx32 < 0 ? -vx32 : vx32;
    ff      = $signed(32'(ms_r)) * ONE + FF_BASE;
    cvy     = onfh ? 32'sd0 : (32'(dvy_r) - vy32) + ff;
    same    = (dvx32 > 0 && vx32 > 0) || (dvx32 < 0 && vx32 < 0);
    cvx     = (same && dvx_abs > vx_abs) ? dvx32 : dvx32 - vx32;
    if (cvx > CMD_LIM) cvx = CMD_LIM;
    if (cvx < -CMD_LIM) cvx = -CMD_LIM;
    if (cvy > CMD_LIM) cvy = CMD_LIM;
    if (cvy < -CMD_LIM) cvy = -CMD_LIM;
    dt = in_r.now_ms - last_r;

    if (!in_r.status_flags[2]) code_c = G_INVULN;
    else if (!emerg_r && onfh && in_r.status_flags[3]) code_c = G_CONGESTED;
    else if (!emerg_r && in_r.status_flags[4]) code_c = G_SKILL;
    else if (last_r != '0 && dt < (emerg_r ? ISSUE_EMERG_MS : ISSUE_MS)) code_c = G_CADENCE;
    else if (!emerg_r && cvx < QUIET_V && cvx > -QUIET_V &&
             cvy < QUIET_V && cvy > -QUIET_V) code_c = G_DEADBAND;
    else if (!in_r.status_flags[5]) code_c = G_FAIL;
    else code_c = G_FIRED;

    res_c = '0;
    res_c.guard_code = code_r;
    if (early_r) begin
      if (code_r == G_BAILOUT) begin
        res_c.trim_vy  = 18'(ms_r) << (FRAC_BITS + 1);
        res_c.since_ms = since_r;
      end
    end else begin
      res_c.fired      = (code_c == G_FIRED);
      res_c.guard_code = code_c;
      res_c.emergency  = emerg_r;
      res_c.cmd_vx     = 20'(cvx);
      res_c.cmd_vy     = 20'(cvy);
      res_c.desired_vx = 20'(dvx_r);
      res_c.desired_vy = 20'(dvy_r);
      res_c.trim_vy    = 18'(ms_r) << (FRAC_BITS + 1);
      res_c.since_ms   = since_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      bailed_r    <= 1'b0;
      cnt_r       <= '0;
      snap_r[0]   <= '0;
      snap_r[1]   <= '0;
      snap_r[2]   <= '0;
      snap_r[3]   <= '0;
      out_valid_r <= 1'b0;
      early_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            in_r    <= in_ch.data;
            state_r <= S_GUARD;
          end
        end
        S_GUARD: begin
          bailed_r <= bail_eff;
          cnt_r    <= cnt_eff;
          cap_r    <= CAP_W'(cap_c);
          since_r  <= since_c;
          ms_r     <= ms_c;
          early_r  <= 1'b1;
          state_r  <= S_OUT;
          if (in_r.mode == MODE_OFF) code_r <= G_OFF;
          else if (!have) code_r <= G_NOSTATE;
          else if (bail_eff) code_r <= G_BAILED;
          else begin
            cnt_r <= cnt_nxt;
            if (!match) begin
              snap_r[0] <= in_r.pos_x;
              snap_r[1] <= in_r.pos_y;
              snap_r[2] <= in_r.vel_x;
              snap_r[3] <= in_r.vel_y;
            end
            if (cnt_nxt >= CNT_W'(STALE_LIMIT)) begin
              bailed_r <= 1'b1;
              code_r   <= G_STALE;
            end else begin
              early_r <= 1'b0;
              state_r <= S_LAW;
            end
          end
        end
        S_LAW: begin
          dvx_r   <= dvx_law;
          dvy_r   <= dvy_law;
          emerg_r <= em_law;
          state_r <= S_ENV;
        end
        S_ENV: begin
          dvx_r   <= DV_W'(dvx_e);
          dvy_r   <= DV_W'(dvy_e);
          emerg_r <= em_e;
          if (bail_e) begin
            bailed_r <= 1'b1;
            early_r  <= 1'b1;
            code_r   <= G_BAILOUT;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_MXX;
          end
        end
        S_MXX: begin
          mul_r   <= mul_a * mul_b;
          state_r <= S_MYY;
        end
        S_MYY: begin
          mul_r   <= mul_a * mul_b;
          sum_r   <= SUM_W'(mul_r);
          state_r <= S_MCC;
        end
        S_MCC: begin
          mul_r   <= mul_a * mul_b;
          sum_r   <= sum_r + SUM_W'(mul_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          state_r <= (sum_r > SUM_W'(mul_r)) ? S_SQRT : S_OUT;
        end
        S_SQRT: begin
          if (u_rsp.done) begin
            mag_r   <= u_res;
            state_r <= S_MX;
          end
        end
        S_MX: begin
          mul_r   <= mul_a * mul_b;
          state_r <= S_DX;
        end
        S_DX: begin
          if (u_rsp.done) begin
            dvx_r   <= q_signed;
            state_r <= S_MY;
          end
        end
        S_MY: begin
          mul_r   <= mul_a * mul_b;
          state_r <= S_DY;
        end
        S_DY: begin
          if (u_rsp.done) begin
            dvy_r   <= q_signed;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_r       <= res_c;
            out_valid_r <= 1'b1;
            if (!early_r && code_c == G_FIRED) last_r <= in_r.now_ms;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_GUARD)
    else $error("accepted transaction did not enter the guard stage");

  a_stale_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STALE_LIMIT))
    else $error("stale count beyond its limit");

  a_bail_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(bailed_r) |-> ($past(state_r) == S_GUARD || $past(state_r) == S_ENV))
    else $error("bail flag set outside the guard or envelope stage");

  a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    u_rsp.done |-> (state_r == S_SQRT || state_r == S_DX || state_r == S_DY))
    else $error("iterative unit finished while no stage awaited it");

endmodule
